@@ hw/rtl/sqts_pkg.sv @@
// ----------------------------------------------------------------------------
// sqts_pkg
// Shared types and constants of the smoothed quadratic temperature sensor.
// ----------------------------------------------------------------------------
package sqts_pkg;

   localparam int VOLT_W      = 16;
   localparam int TEMP_W      = 16;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int MUL_A_W     = 33;
   localparam int MUL_B_W     = 18;
   localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_CONST = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_LIN   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_QUAD  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WARMUP_LEN = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_MIN   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_MAX   = 3'd6;

   // Sensor status codes.
   localparam logic [STATUS_W-1:0] STATUS_OFFLINE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INIT    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RUNNING = 2'd2;

   typedef struct packed {
      logic        [8:0]  alpha;
      logic signed [31:0] coef_const;
      logic signed [31:0] coef_lin;
      logic signed [31:0] coef_quad;
      logic        [7:0]  warmup_len;
      logic signed [15:0] temp_min;
      logic signed [15:0] temp_max;
   } cfg_type;

endpackage

@@ hw/rtl/sqts_ifs.sv @@
// ----------------------------------------------------------------------------
// sqts channel interfaces
// Valid/ready channels for sensor readings and temperature results.
// ----------------------------------------------------------------------------
interface sqts_req_if;
   import sqts_pkg::*;

   logic              valid;
   logic              ready;
   logic              read_ok;
   logic [VOLT_W-1:0] sample_voltage;

   modport source (output valid, output read_ok, output sample_voltage, input ready);
   modport sink   (input valid, input read_ok, input sample_voltage, output ready);
endinterface

interface sqts_rsp_if;
   import sqts_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [TEMP_W-1:0]   temperature;
   logic        [VOLT_W-1:0]   filtered_voltage;
   logic        [STATUS_W-1:0] sensor_status;
   logic                       out_of_range;

   modport source (output valid, output temperature, output filtered_voltage,
                   output sensor_status, output out_of_range, input ready);
   modport sink   (input valid, input temperature, input filtered_voltage,
                   input sensor_status, input out_of_range, output ready);
endinterface

@@ hw/rtl/sqts_csr.sv @@
// ----------------------------------------------------------------------------
// sqts_csr
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module sqts_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [sqts_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sqts_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output sqts_pkg::cfg_type                  cfg
);
   import sqts_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ALPHA:      cfg_in.alpha      = csr_wdata[8:0];
            CSR_COEF_CONST: cfg_in.coef_const = csr_wdata;
            CSR_COEF_LIN:   cfg_in.coef_lin   = csr_wdata;
            CSR_COEF_QUAD:  cfg_in.coef_quad  = csr_wdata;
            CSR_WARMUP_LEN: cfg_in.warmup_len = csr_wdata[7:0];
            CSR_TEMP_MIN:   cfg_in.temp_min   = csr_wdata[15:0];
            CSR_TEMP_MAX:   cfg_in.temp_max   = csr_wdata[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha      <= 9'd77;
         cfg_ff.coef_const <= '0;
         cfg_ff.coef_lin   <= '0;
         cfg_ff.coef_quad  <= '0;
         cfg_ff.warmup_len <= 8'd30;
         cfg_ff.temp_min   <= -16'sd7680;
         cfg_ff.temp_max   <= 16'sd25600;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/sqts_mul.sv @@
// ----------------------------------------------------------------------------
// sqts_mul
// Shared signed 33 x 18 multiplier used by every arithmetic step of the sequencer.
// ----------------------------------------------------------------------------
module sqts_mul (
   input  logic signed [sqts_pkg::MUL_A_W-1:0] op_a,
   input  logic signed [sqts_pkg::MUL_B_W-1:0] op_b,
   output logic signed [sqts_pkg::MUL_P_W-1:0] prod
);
   import sqts_pkg::*;

   assign prod = MUL_P_W'(op_a) * MUL_P_W'(op_b);

endmodule

@@ hw/rtl/smoothed_quadratic_temp_sensor_unit.sv @@
// ----------------------------------------------------------------------------
// smoothed_quadratic_temp_sensor_unit
// Exponential smoothing of sensor voltages followed by a quadratic
// calibration to temperature, with warm-up status and range flagging.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Carries
//   req_ch    in          read_ok, sample_voltage
//   rsp_ch    out         temperature, filtered_voltage, sensor_status,
//                         out_of_range
//   csr_*     in          write enable, register index, write data
//
// Items are accepted only in the idle step. A good reading with history runs six steps
// on the shared multiplier (two for the average, square, linear, two for the quadratic
// term) and then the finish step, which loads its result; the next item is accepted
// only after the sequencer is back in the idle step. The first reading after a clear
// skips the average; a failed read goes straight to finish. Reset is synchronous,
// active high; a result stalled on rsp_ch holds the next item in finish.
// ----------------------------------------------------------------------------
module smoothed_quadratic_temp_sensor_unit (
   input  logic                              clock,
   input  logic                              reset,
   sqts_req_if.sink                          req_ch,
   sqts_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [sqts_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sqts_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import sqts_pkg::*;

   // Sequencer steps.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_F1   = 3'd1;
   localparam logic [2:0] ST_F2   = 3'd2;
   localparam logic [2:0] ST_SQ   = 3'd3;
   localparam logic [2:0] ST_LIN  = 3'd4;
   localparam logic [2:0] ST_QLO  = 3'd5;
   localparam logic [2:0] ST_QHI  = 3'd6;
   localparam logic [2:0] ST_DONE = 3'd7;

   cfg_type cfg;

   sqts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Control state.
   logic [2:0] state_ff, state_in;
   logic       have_hist_ff, have_hist_in;
   logic [7:0] count_ff, count_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Item and datapath registers.
   logic                     ok_ff, ok_in;
   logic [VOLT_W-1:0]        volt_ff, volt_in;
   logic [VOLT_W-1:0]        prev_ff, prev_in;
   logic [VOLT_W-1:0]        filt_ff, filt_in;
   logic [24:0]              acc_ff, acc_in;
   logic [31:0]              sq_ff, sq_in;
   logic signed [36:0]       lsum_ff, lsum_in;
   logic signed [65:0]       q_ff, q_in;
   logic signed [TEMP_W-1:0] last_temp_ff, last_temp_in;

   // Result register.
   logic signed [TEMP_W-1:0] out_temp_ff, out_temp_in;
   logic [VOLT_W-1:0]        out_filt_ff, out_filt_in;
   logic [STATUS_W-1:0]      out_status_ff, out_status_in;
   logic                     out_flag_ff, out_flag_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] prod;
   logic [8:0]                alpha_sat;
   logic [24:0]               avg_sum;
   logic signed [MUL_P_W-1:0] lin_sh;
   logic signed [65:0]        q_sh;
   logic signed [40:0]        temp_wide;
   logic signed [TEMP_W-1:0]  temp_sat;
   logic [7:0]                count_next;
   logic                      out_free;

   sqts_mul u_mul (
      .op_a (mul_a),
      .op_b (mul_b),
      .prod (prod)
   );

   assign alpha_sat = (cfg.alpha > 9'd256) ? 9'd256 : cfg.alpha;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   // Operand selection for the shared multiplier.
   always_comb begin
      case (state_ff)
         ST_F1: begin
            mul_a = MUL_A_W'(9'd256 - alpha_sat);
            mul_b = MUL_B_W'(prev_ff);
         end
         ST_F2: begin
            mul_a = MUL_A_W'(alpha_sat);
            mul_b = MUL_B_W'(volt_ff);
         end
         ST_SQ: begin
            mul_a = MUL_A_W'(filt_ff);
            mul_b = MUL_B_W'(filt_ff);
         end
         ST_LIN: begin
            mul_a = MUL_A_W'(cfg.coef_lin);
            mul_b = MUL_B_W'(filt_ff);
         end
         ST_QLO: begin
            mul_a = MUL_A_W'(cfg.coef_quad);
            mul_b = MUL_B_W'(sq_ff[15:0]);
         end
         ST_QHI: begin
            mul_a = MUL_A_W'(cfg.coef_quad);
            mul_b = MUL_B_W'(sq_ff[31:16]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Rounded weighted average; never exceeds 16 bits after the shift.
   assign avg_sum = acc_ff + prod[24:0] + 25'd128;
   // Arithmetic right shifts give the floor of the scaled products.
   assign lin_sh  = prod >>> 13;
   assign q_sh    = q_ff >>> 26;
   assign temp_wide = 41'(lsum_ff) + q_sh[40:0];

   always_comb begin
      if (temp_wide > 41'sd32767) begin
         temp_sat = 16'sh7fff;
      end else if (temp_wide < -41'sd32768) begin
         temp_sat = 16'sh8000;
      end else begin
         temp_sat = temp_wide[15:0];
      end
   end

   assign count_next = (count_ff == 8'd255) ? count_ff : count_ff + 8'd1;

   always_comb begin
      state_in      = state_ff;
      have_hist_in  = have_hist_ff;
      count_in      = count_ff;
      status_in     = status_ff;
      ok_in         = ok_ff;
      volt_in       = volt_ff;
      prev_in       = prev_ff;
      filt_in       = filt_ff;
      acc_in        = acc_ff;
      sq_in         = sq_ff;
      lsum_in       = lsum_ff;
      q_in          = q_ff;
      last_temp_in  = last_temp_ff;
      out_temp_in   = out_temp_ff;
      out_filt_in   = out_filt_ff;
      out_status_in = out_status_ff;
      out_flag_in   = out_flag_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               ok_in   = req_ch.read_ok;
               volt_in = req_ch.sample_voltage;
               if (!req_ch.read_ok) begin
                  state_in = ST_DONE;
               end else if (have_hist_ff) begin
                  state_in = ST_F1;
               end else begin
                  // The first sample after a clear passes through unchanged.
                  filt_in  = req_ch.sample_voltage;
                  state_in = ST_SQ;
               end
            end
         end
         ST_F1: begin
            acc_in   = prod[24:0];
            state_in = ST_F2;
         end
         ST_F2: begin
            filt_in  = avg_sum[23:8];
            state_in = ST_SQ;
         end
         ST_SQ: begin
            sq_in    = prod[31:0];
            state_in = ST_LIN;
         end
         ST_LIN: begin
            lsum_in  = 37'(cfg.coef_const) + lin_sh[36:0];
            state_in = ST_QLO;
         end
         ST_QLO: begin
            q_in     = 66'(prod);
            state_in = ST_QHI;
         end
         ST_QHI: begin
            q_in     = q_ff + {prod[49:0], 16'b0};
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (!ok_ff) begin
                  // Failed read: go offline and drop the filter history.
                  status_in     = STATUS_OFFLINE;
                  have_hist_in  = 1'b0;
                  prev_in       = '0;
                  count_in      = '0;
                  out_temp_in   = last_temp_ff;
                  out_filt_in   = '0;
                  out_status_in = STATUS_OFFLINE;
                  out_flag_in   = 1'b0;
               end else begin
                  last_temp_in = temp_sat;
                  prev_in      = filt_ff;
                  have_hist_in = 1'b1;
                  count_in     = count_next;
                  out_temp_in  = temp_sat;
                  out_filt_in  = filt_ff;
                  if (count_next >= cfg.warmup_len) begin
                     status_in     = STATUS_RUNNING;
                     out_status_in = STATUS_RUNNING;
                     out_flag_in   = (temp_sat < cfg.temp_min) ||
                                     (temp_sat > cfg.temp_max);
                  end else begin
                     status_in     = STATUS_INIT;
                     out_status_in = STATUS_INIT;
                     out_flag_in   = 1'b0;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_hist_ff <= 1'b0;
         count_ff     <= '0;
         status_ff    <= STATUS_OFFLINE;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         last_temp_ff <= '0;
      end else begin
         state_ff     <= state_in;
         have_hist_ff <= have_hist_in;
         count_ff     <= count_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
         last_temp_ff <= last_temp_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff         <= ok_in;
      volt_ff       <= volt_in;
      filt_ff       <= filt_in;
      acc_ff        <= acc_in;
      sq_ff         <= sq_in;
      lsum_ff       <= lsum_in;
      q_ff          <= q_in;
      out_temp_ff   <= out_temp_in;
      out_filt_ff   <= out_filt_in;
      out_status_ff <= out_status_in;
      out_flag_ff   <= out_flag_in;
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.temperature      = out_temp_ff;
   assign rsp_ch.filtered_voltage = out_filt_ff;
   assign rsp_ch.sensor_status    = out_status_ff;
   assign rsp_ch.out_of_range     = out_flag_ff;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the smoothed quadratic temperature sensor: drives
// readings over the request channel, predicts every result in step with the
// accepted items and compares the result channel field by field.
// ----------------------------------------------------------------------------
module tb_top;
   import sqts_pkg::*;

   localparam int HALF_PERIOD      = 5;
   localparam int RESET_CYCLES     = 8;
   localparam int SETTLE_CYCLES    = 10;   // idle gap before register writes
   localparam int DRAIN_CYCLES     = 20;   // drain time before the run ends
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT      = 2000; // cycles without any handshake or register write

   // Idling patterns of the two channel ends.
   typedef enum int unsigned {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // One sensor reading as it travels on the request channel.
   typedef struct {
      bit                read_ok;
      bit [VOLT_W-1:0]   voltage;
   } reading_type;

   // One result item as it should appear on the result channel.
   typedef struct {
      logic signed [TEMP_W-1:0]   temperature;
      logic        [VOLT_W-1:0]   filtered_voltage;
      logic        [STATUS_W-1:0] sensor_status;
      logic                       out_of_range;
   } temp_result_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   sqts_req_if req_if ();
   sqts_rsp_if rsp_if ();

   smoothed_quadratic_temp_sensor_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Readings waiting to be offered, and the results they are predicted to
   // produce, oldest first.
   reading_type     pending_readings[$];
   temp_result_type expected_results[$];

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_requests  = 0;
   int unsigned error_count    = 0;
   int unsigned results_seen   = 0;
   int unsigned quiet_cycles   = 0;
   bit          req_taken      = 1'b0;

   // Shadow of the sensor's registers and of its filter state.
   cfg_type                  sensor_cfg;
   logic [VOLT_W-1:0]        last_filtered    = '0;
   bit                       history_valid    = 1'b0;
   int unsigned              good_count       = 0;
   logic signed [TEMP_W-1:0] held_temperature = '0;

   // Computes the result of one reading and advances the shadow state. A
   // failed read clears the history and repeats the last temperature; a good
   // one is averaged, calibrated, saturated and judged against the limits.
   function automatic temp_result_type predict_reading(reading_type rd);
      temp_result_type   res;
      int unsigned       weight;
      logic [VOLT_W-1:0] filt;
      longint            volt;
      longint            temp_wide;
      if (!rd.read_ok) begin
         history_valid        = 1'b0;
         last_filtered        = '0;
         good_count           = 0;
         res.temperature      = held_temperature;
         res.filtered_voltage = '0;
         res.sensor_status    = STATUS_OFFLINE;
         res.out_of_range     = 1'b0;
         return res;
      end
      if (history_valid) begin
         // A weight above 256 behaves as 256.
         weight = (sensor_cfg.alpha > 9'd256) ? 256 : sensor_cfg.alpha;
         filt   = VOLT_W'(((256 - weight) * last_filtered + weight * rd.voltage + 128) >> 8);
      end else begin
         filt = rd.voltage;
      end
      volt      = longint'(filt);
      temp_wide = longint'(sensor_cfg.coef_const)
                + ((longint'(sensor_cfg.coef_lin) * volt) >>> 13)
                + ((longint'(sensor_cfg.coef_quad) * volt * volt) >>> 26);
      if (temp_wide > 32767) begin
         temp_wide = 32767;
      end else if (temp_wide < -32768) begin
         temp_wide = -32768;
      end
      res.temperature      = TEMP_W'(temp_wide);
      res.filtered_voltage = filt;
      held_temperature     = res.temperature;
      last_filtered        = filt;
      history_valid        = 1'b1;
      if (good_count < 255) begin
         good_count++;
      end
      if (good_count >= sensor_cfg.warmup_len) begin
         res.sensor_status = STATUS_RUNNING;
         res.out_of_range  = (temp_wide < longint'(sensor_cfg.temp_min)) ||
                             (temp_wide > longint'(sensor_cfg.temp_max));
      end else begin
         res.sensor_status = STATUS_INIT;
         res.out_of_range  = 1'b0;
      end
      return res;
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] MISMATCH result %0d: %s", $realtime, results_seen, msg);
      error_count++;
   endtask

   // Request side: an item is taken at a rising edge with valid and ready
   // both high, and its result is predicted right there.
   always @(posedge clock) begin
      req_taken <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready) begin
         expected_results.push_back(predict_reading('{req_if.read_ok, req_if.sample_voltage}));
      end
   end

   // The driver offers a new item once the previous one was taken, unless it
   // decides to idle for this cycle. An item on offer is held until taken.
   always @(negedge clock) begin : req_driver
      reading_type next_rd;
      if (!reset && (!req_if.valid || req_taken)) begin
         if (pending_readings.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_rd = pending_readings.pop_front();
            req_if.valid          <= 1'b1;
            req_if.read_ok        <= next_rd.read_ok;
            req_if.sample_voltage <= next_rd.voltage;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // The receiver stalls at random, and on request holds ready low for a
   // long stretch so that the block backs up into its input.
   always @(negedge clock) begin : rsp_receiver
      int unsigned hold_seen;
      int unsigned hold_left;
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Every result item is checked against the oldest prediction.
   always @(posedge clock) begin : rsp_checker
      temp_result_type want;
      if (rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result item with none expected (temperature %0d)",
                                      rsp_if.temperature));
         end else begin
            want = expected_results.pop_front();
            if (rsp_if.temperature !== want.temperature)
               report_mismatch($sformatf("temperature %0d, expected %0d",
                                         rsp_if.temperature, want.temperature));
            if (rsp_if.filtered_voltage !== want.filtered_voltage)
               report_mismatch($sformatf("filtered_voltage %0d, expected %0d",
                                         rsp_if.filtered_voltage, want.filtered_voltage));
            if (rsp_if.sensor_status !== want.sensor_status)
               report_mismatch($sformatf("sensor_status %0d, expected %0d",
                                         rsp_if.sensor_status, want.sensor_status));
            if (rsp_if.out_of_range !== want.out_of_range)
               report_mismatch($sformatf("out_of_range %0b, expected %0b",
                                         rsp_if.out_of_range, want.out_of_range));
         end
         results_seen++;
      end
   end

   // Watchdog: the run is stuck if no handshake of any kind and no register
   // write happen for a long time.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_reading(bit ok, bit [VOLT_W-1:0] volt);
      pending_readings.push_back('{ok, volt});
   endtask

   // Waits until every item has been taken and every result has arrived,
   // sampled at the rising edge where the driver's updates have settled.
   task automatic wait_until_idle();
      while (pending_readings.size() != 0 || req_if.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_idling(idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct  = 66;
            recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct  = 0;
            recv_stall_pct = 66;
         end
         default: begin
            send_idle_pct  = 34;
            recv_stall_pct = 34;
         end
      endcase
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   // Writes all seven registers while the block is idle. The unused upper
   // bits of the narrow registers carry random junk, which must be ignored.
   task automatic apply_settings(cfg_type c);
      logic [CSR_DATA_W-1:0] junk;
      wait_until_idle();
      junk = $urandom;
      write_csr(CSR_ALPHA,      {junk[CSR_DATA_W-1:9], c.alpha});
      write_csr(CSR_COEF_CONST, c.coef_const);
      write_csr(CSR_COEF_LIN,   c.coef_lin);
      write_csr(CSR_COEF_QUAD,  c.coef_quad);
      junk = $urandom;
      write_csr(CSR_WARMUP_LEN, {junk[CSR_DATA_W-1:8], c.warmup_len});
      junk = $urandom;
      write_csr(CSR_TEMP_MIN,   {junk[CSR_DATA_W-1:16], c.temp_min});
      junk = $urandom;
      write_csr(CSR_TEMP_MAX,   {junk[CSR_DATA_W-1:16], c.temp_max});
      @(negedge clock);
      csr_we     <= 1'b0;
      sensor_cfg  = c;
   endtask

   function automatic cfg_type make_settings(logic [8:0] alpha, logic [31:0] c0,
                                             logic [31:0] c1, logic [31:0] c2,
                                             logic [7:0] warmup, logic [15:0] lo,
                                             logic [15:0] hi);
      cfg_type c;
      c.alpha      = alpha;
      c.coef_const = c0;
      c.coef_lin   = c1;
      c.coef_quad  = c2;
      c.warmup_len = warmup;
      c.temp_min   = lo;
      c.temp_max   = hi;
      return c;
   endfunction

   // Random settings: mostly a plausible calibration whose temperatures land
   // around the limits, sometimes full-range coefficients that saturate.
   function automatic cfg_type random_settings(bit wide_coefs);
      cfg_type c;
      int      lo;
      int      hi;
      c.alpha = ($urandom_range(7) == 0) ? 9'($urandom_range(511)) : 9'($urandom_range(256));
      if (wide_coefs) begin
         c.coef_const = $urandom;
         c.coef_lin   = $urandom;
         c.coef_quad  = $urandom;
      end else begin
         c.coef_const = $urandom_range(16000) - 8000;
         c.coef_lin   = $urandom_range(60000) - 30000;
         c.coef_quad  = $urandom_range(8000) - 4000;
      end
      c.warmup_len = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) :
                                                8'($urandom_range(12, 1));
      lo = int'($urandom_range(30000)) - 15000;
      hi = lo + int'($urandom_range(20000));
      if (hi > 32767) begin
         hi = 32767;
      end
      // Now and then the limits are crossed.
      if ($urandom_range(7) == 0) begin
         c.temp_min = 16'(hi);
         c.temp_max = 16'(lo);
      end else begin
         c.temp_min = 16'(lo);
         c.temp_max = 16'(hi);
      end
      return c;
   endfunction

   // Voltages mostly wander around a working point like a real sensor, with
   // the rails and fully random values mixed in.
   function automatic bit [VOLT_W-1:0] pick_voltage(int center);
      int v;
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3:    return VOLT_W'($urandom);
         default: begin
            v = center + int'($urandom_range(512)) - 256;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            return VOLT_W'(v);
         end
      endcase
   endfunction

   initial begin : stimulus
      cfg_type     cfg;
      int unsigned fail_pm;
      int unsigned count;
      int          center;

      req_if.valid          = 1'b0;
      req_if.read_ok        = 1'b0;
      req_if.sample_voltage = '0;
      rsp_if.ready          = 1'b0;
      sensor_cfg = make_settings(9'd77, 32'sd0, 32'sd0, 32'sd0, 8'd30, -16'sd7680, 16'sd25600);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed items on the reset settings: a failed read while offline, then
      // the first sample after a clear, one averaged sample and a failed read.
      set_idling(IDLE_NONE);
      queue_reading(1'b0, 16'h0000);
      queue_reading(1'b1, 16'h1234);
      queue_reading(1'b1, 16'h1234);
      queue_reading(1'b0, 16'hFFFF);

      // Weight above 256 saturates, no warm-up at all, voltage rails, and a
      // failed read in the middle that must restart from a pass-through.
      apply_settings(make_settings(9'd300, 32'sd6400, 32'sd25000, -32'sd2000, 8'd0,
                                   -16'sd1000, 16'sd9000));
      queue_reading(1'b1, 16'h0000);
      queue_reading(1'b1, 16'hFFFF);
      queue_reading(1'b1, 16'h8000);
      queue_reading(1'b1, 16'h0001);
      queue_reading(1'b0, 16'hAAAA);
      queue_reading(1'b1, 16'h5555);
      queue_reading(1'b1, 16'h7FFF);

      // Largest coefficients saturate high; zero weight freezes the average;
      // crossed limits flag every temperature.
      apply_settings(make_settings(9'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd1,
                                   16'sh7FFF, 16'sh8000));
      queue_reading(1'b1, 16'hFFFF);
      queue_reading(1'b1, 16'h0000);
      queue_reading(1'b1, 16'h0001);
      queue_reading(1'b0, 16'h0000);

      // Most negative coefficients saturate low; full weight follows the
      // input exactly; the widest limits never flag.
      apply_settings(make_settings(9'd256, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'd2,
                                   16'sh8000, 16'sh7FFF));
      queue_reading(1'b1, 16'hFFFF);
      queue_reading(1'b1, 16'h0000);
      queue_reading(1'b1, 16'hFFFF);
      queue_reading(1'b1, 16'h4000);

      // Random phases, each with its own settings and idling pattern.
      for (int p = 0; p < 8; p++) begin
         cfg     = random_settings(p % 3 == 2);
         fail_pm = (p % 2 != 0) ? 20 : 80;
         count   = 120;
         if (p == 5) begin
            // A long unbroken run: the sample count saturates and the block
            // reaches running only at the longest warm-up.
            cfg.warmup_len = 8'd255;
            fail_pm        = 0;
            count          = 300;
         end
         apply_settings(cfg);
         set_idling(idle_mode_type'(p % 4));
         center = $urandom_range(16000, 2000);
         if (p == 4) begin
            // The receiver holds off while the sender keeps offering items.
            hold_requests++;
         end
         for (int i = 0; i < count; i++) begin
            if (p == 3 && i == count / 2) begin
               // The sender pauses until every result has come back.
               wait_until_idle();
            end
            queue_reading($urandom_range(999) >= fail_pm, pick_voltage(center));
         end
      end

      wait_until_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ smoothed_quadratic_temp_sensor_unit.f @@
hw/rtl/sqts_pkg.sv
hw/rtl/sqts_ifs.sv
hw/rtl/sqts_csr.sv
hw/rtl/sqts_mul.sv
hw/rtl/smoothed_quadratic_temp_sensor_unit.sv
test/tb_top.sv
